// ===== design/sts_pkg.sv =====
package sts_pkg;

	// default sizes handed to the top level
	localparam int DEF_MAX_LEN = 1024;
	localparam int DEF_MAX_WIN = 128;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIES_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MANT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT   = 2'd3;

	// configuration reset values
	localparam logic [10:0] RST_SERIES_LENGTH = 11'd1024;
	localparam logic [7:0]  RST_WINDOW_SIZE   = 8'd76;
	localparam logic [15:0] RST_SCALE_MANT    = 16'd39140;
	localparam logic [5:0]  RST_SCALE_SHIFT   = 6'd44;

	// result status codes
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	// mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// datapath widths
	localparam int BIN_W   = 16;
	localparam int WORD_W  = 32;
	localparam int PROD_W  = 33;
	localparam int TERM_W  = 66;
	localparam int ACC_W   = 96;
	localparam int MANT_W  = 16;
	localparam int SCL_W   = ACC_W + MANT_W;
	localparam int OUT_W   = 40;
	localparam int OUT_SHIFT_EXTRA = 28;

	// sequencer to term pipeline
	typedef struct packed {
		logic                     clr;
		logic                     issue;
		logic signed [PROD_W-1:0] p_re;
		logic signed [PROD_W-1:0] p_im;
	} term_ctl_t;

endpackage

// ===== design/sts_store.sv =====
module sts_store #(
	parameter int MAX_LEN = sts_pkg::DEF_MAX_LEN,
	localparam int AW = $clog2(MAX_LEN)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [sts_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]             raddr_a,
	input  logic [AW-1:0]             raddr_b,
	output logic [sts_pkg::WORD_W-1:0] rdata_a,
	output logic [sts_pkg::WORD_W-1:0] rdata_b
);

	// two copies of the bin store so two bins can be read per cycle
	logic [sts_pkg::WORD_W-1:0] mem_a [MAX_LEN];
	logic [sts_pkg::WORD_W-1:0] mem_b [MAX_LEN];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[waddr] <= wdata;
		end
		rdata_a <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_b[waddr] <= wdata;
		end
		rdata_b <= mem_b[raddr_b];
	end

endmodule

// ===== design/sts_term.sv =====
module sts_term (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sts_pkg::term_ctl_t                ctl,
	input  logic [sts_pkg::WORD_W-1:0]        e_data,
	input  logic [sts_pkg::WORD_W-1:0]        s_data,
	output logic signed [sts_pkg::ACC_W-1:0]  acc_re,
	output logic signed [sts_pkg::ACC_W-1:0]  acc_im,
	output logic                              busy
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [sts_pkg::BIN_W-1:0]  er, ei, xr, xi;
	logic signed [31:0]                m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [sts_pkg::PROD_W-1:0] qr_s3, qi_s3;
	logic signed [sts_pkg::TERM_W-1:0] t1_s4, t2_s4, t3_s4, t4_s4;
	logic signed [sts_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;

	assign er = signed'(e_data[31:16]);
	assign ei = signed'(e_data[15:0]);
	assign xr = signed'(s_data[31:16]);
	assign xi = signed'(s_data[15:0]);

	// valid chain; read data lines up with v_s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// q = F[e] * conj(F[s]), then term = p * q
	always_ff @(posedge clk) begin
		m1_s2 <= er * xr;
		m2_s2 <= ei * xi;
		m3_s2 <= ei * xr;
		m4_s2 <= er * xi;
		qr_s3 <= sts_pkg::PROD_W'(m1_s2) + sts_pkg::PROD_W'(m2_s2);
		qi_s3 <= sts_pkg::PROD_W'(m3_s2) - sts_pkg::PROD_W'(m4_s2);
		t1_s4 <= ctl.p_re * qr_s3;
		t2_s4 <= ctl.p_im * qi_s3;
		t3_s4 <= ctl.p_re * qi_s3;
		t4_s4 <= ctl.p_im * qr_s3;
	end

	// running sums
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s4) begin
			acc_re_q <= acc_re_q + sts_pkg::ACC_W'(t1_s4) - sts_pkg::ACC_W'(t2_s4);
			acc_im_q <= acc_im_q + sts_pkg::ACC_W'(t3_s4) + sts_pkg::ACC_W'(t4_s4);
		end
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;
	assign busy   = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

// ===== design/sts_scale.sv =====
module sts_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [sts_pkg::ACC_W-1:0]  acc_re,
	input  logic signed [sts_pkg::ACC_W-1:0]  acc_im,
	input  logic [sts_pkg::MANT_W-1:0]        mant,
	input  logic [5:0]                        shift,
	output logic                              done,
	output logic [sts_pkg::OUT_W-1:0]         res_re,
	output logic [sts_pkg::OUT_W-1:0]         res_im
);

	localparam int KW = $clog2(sts_pkg::MANT_W);

	logic                              run_q, shf_q, done_q;
	logic [KW-1:0]                     k_q;
	logic [sts_pkg::MANT_W-1:0]        mant_q;
	logic signed [sts_pkg::SCL_W-1:0]  mr_q, mi_q, pr_q, pi_q;
	logic [6:0]                        amt;

	assign amt = 7'(shift) + 7'(sts_pkg::OUT_SHIFT_EXTRA);

	// control: 16 shift-add steps, one shift step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			shf_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			shf_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else if (run_q) begin
			k_q <= k_q + 1'b1;
			if (k_q == KW'(sts_pkg::MANT_W - 1)) begin
				run_q <= 1'b0;
				shf_q <= 1'b1;
			end
		end else if (shf_q) begin
			shf_q  <= 1'b0;
			done_q <= 1'b1;
		end
	end

	// serial multiply by the mantissa, then arithmetic right shift
	always_ff @(posedge clk) begin
		if (start) begin
			mr_q   <= sts_pkg::SCL_W'(acc_re);
			mi_q   <= sts_pkg::SCL_W'(acc_im);
			pr_q   <= '0;
			pi_q   <= '0;
			mant_q <= mant;
		end else if (run_q) begin
			if (mant_q[k_q]) begin
				pr_q <= pr_q + mr_q;
				pi_q <= pi_q + mi_q;
			end
			mr_q <= mr_q <<< 1;
			mi_q <= mi_q <<< 1;
		end else if (shf_q) begin
			pr_q <= pr_q >>> amt;
			pi_q <= pi_q >>> amt;
		end
	end

	// saturate to the signed output range
	function automatic logic [sts_pkg::OUT_W-1:0] sat(input logic signed [sts_pkg::SCL_W-1:0] v);
		logic [sts_pkg::SCL_W-sts_pkg::OUT_W:0] top;
		top = v[sts_pkg::SCL_W-1:sts_pkg::OUT_W-1];
		if (top == '0 || top == '1)
			sat = v[sts_pkg::OUT_W-1:0];
		else if (v[sts_pkg::SCL_W-1])
			sat = {1'b1, {(sts_pkg::OUT_W-1){1'b0}}};
		else
			sat = {1'b0, {(sts_pkg::OUT_W-1){1'b1}}};
	endfunction

	assign done   = done_q;
	assign res_re = sat(pr_q);
	assign res_im = sat(pi_q);

endmodule

// ===== design/smoothed_trispectrum_point.sv =====
// Smoothed trispectrum point.
// Input channel (in_valid/in_ready): mode 0 beats load one complex Q1.15 bin
// into the bin store; mode 1 beats ask for one box-smoothed trispectrum point
// over a window cube. Each input beat yields exactly one output beat
// (out_valid/out_ready) with status and a saturated Q8.32 complex value.
// Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken and must only be sent while the block is idle.
// A load, or a query outside the valid range, answers in the cycle after it is
// accepted. A query walks its window with one term issued per cycle on the
// two-copy bin store; its run time is set by the term count and by the
// inner-loop drains of the term pipeline.
// One item is worked on at a time. A finished result sits in the output
// register while the next load or bad query can be taken if the receiver
// takes the beat in the same cycle; a stalled receiver holds the block.
// Reset restores the register defaults; the bin store is not cleared and
// every bin a query touches must have been loaded first.
module smoothed_trispectrum_point #(
	parameter int MAX_LEN = sts_pkg::DEF_MAX_LEN,
	parameter int MAX_WIN = sts_pkg::DEF_MAX_WIN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [9:0]                      bin_index,
	input  logic signed [15:0]              bin_re,
	input  logic signed [15:0]              bin_im,
	input  logic [9:0]                      row_start,
	input  logic [9:0]                      col_start,
	input  logic [9:0]                      depth_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            status,
	output logic signed [39:0]              value_re,
	output logic signed [39:0]              value_im,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int XW = (AW > 11) ? AW : 11;
	localparam int CW = $clog2(MAX_WIN + 1);

	typedef enum logic [3:0] {
		IDLE, A_CHK, A_LATCH, B_CHK, B_LATCH, B_SUM,
		E_RUN, E_DRAIN, SC, SC_WAIT, FINISH
	} state_t;

	state_t state_q;

	logic [10:0] n_q;
	logic [7:0]  w_q;
	logic [15:0] mant_q;
	logic [5:0]  shift_q;
	logic [9:0]  row_q, col_q, dend_q;
	logic [CW-1:0] r_q, c_q;
	logic [XW-1:0] a_q, b_q, e_q;
	logic signed [15:0] a_re_q, a_im_q;
	logic signed [31:0] m1_q, m2_q, m3_q, m4_q;
	logic signed [sts_pkg::PROD_W-1:0] pr_q, pi_q;
	logic out_valid_q, status_q;
	logic [39:0] val_re_q, val_im_q;

	logic [XW-1:0]   a_idx, b_idx;
	logic [XW+1:0]   s_idx;
	logic            e_ok, issue, bad, out_free, in_acc, res_load;
	logic [11:0]     nn, ww;
	logic [XW-1:0]   rd_a_idx;
	logic [31:0]     rdata_a, rdata_b;
	logic signed [15:0] b_re, b_im;
	logic            we;
	sts_pkg::term_ctl_t tctl;
	logic signed [sts_pkg::ACC_W-1:0] acc_re, acc_im;
	logic            term_busy, sc_done;
	logic [39:0]     sc_re, sc_im;

	// index arithmetic for the window walk
	assign a_idx = XW'(row_q) + XW'(r_q);
	assign b_idx = XW'(col_q) + XW'(c_q);
	assign s_idx = (XW+2)'(a_q) + (XW+2)'(b_q) + (XW+2)'(e_q);
	assign e_ok  = (e_q <= XW'(dend_q)) && (e_q <= b_q)
	             && ((XW+3)'({s_idx, 1'b0}) < (XW+3)'(n_q));
	assign issue = (state_q == E_RUN) && e_ok;

	// range check of a query against the configuration
	assign nn  = 12'(n_q);
	assign ww  = 12'(w_q);
	assign bad = (n_q == '0) || (32'(n_q) > MAX_LEN) || (w_q == '0)
	          || (32'(w_q) > MAX_WIN) || (ww > nn)
	          || (12'(row_start) > nn - ww) || (12'(col_start) > nn - ww)
	          || (12'(depth_end) + 12'd1 < ww) || (12'(depth_end) >= nn);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;
	assign we       = in_acc && (mode == sts_pkg::MODE_LOAD) && (32'(bin_index) < MAX_LEN);

	// result register is loaded by a quick answer or a finished query
	assign res_load = (in_acc && (mode == sts_pkg::MODE_LOAD || bad))
	               || ((state_q == FINISH) && out_free);

	// read address mux for store port A
	always_comb begin
		case (state_q)
			A_CHK:   rd_a_idx = a_idx;
			B_CHK:   rd_a_idx = b_idx;
			default: rd_a_idx = e_q;
		endcase
	end

	assign b_re = signed'(rdata_a[31:16]);
	assign b_im = signed'(rdata_a[15:0]);

	sts_store #(.MAX_LEN(MAX_LEN)) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (AW'(bin_index)),
		.wdata   ({bin_re, bin_im}),
		.raddr_a (AW'(rd_a_idx)),
		.raddr_b (AW'(s_idx)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign tctl.clr   = in_acc && (mode == sts_pkg::MODE_QUERY);
	assign tctl.issue = issue;
	assign tctl.p_re  = pr_q;
	assign tctl.p_im  = pi_q;

	sts_term u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.e_data (rdata_a),
		.s_data (rdata_b),
		.acc_re (acc_re),
		.acc_im (acc_im),
		.busy   (term_busy)
	);

	sts_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == SC),
		.acc_re (acc_re),
		.acc_im (acc_im),
		.mant   (mant_q),
		.shift  (shift_q),
		.done   (sc_done),
		.res_re (sc_re),
		.res_im (sc_im)
	);

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= sts_pkg::RST_SERIES_LENGTH;
			w_q     <= sts_pkg::RST_WINDOW_SIZE;
			mant_q  <= sts_pkg::RST_SCALE_MANT;
			shift_q <= sts_pkg::RST_SCALE_SHIFT;
		end else if (cfg_valid) begin
			case (cfg_index)
				sts_pkg::CFG_SERIES_LENGTH: n_q     <= cfg_data[10:0];
				sts_pkg::CFG_WINDOW_SIZE:   w_q     <= cfg_data[7:0];
				sts_pkg::CFG_SCALE_MANT:    mant_q  <= cfg_data;
				sts_pkg::CFG_SCALE_SHIFT:   shift_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			status_q    <= sts_pkg::ST_OK;
			val_re_q    <= '0;
			val_im_q    <= '0;
			r_q         <= '0;
			c_q         <= '0;
			e_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			row_q       <= '0;
			col_q       <= '0;
			dend_q      <= '0;
			a_re_q      <= '0;
			a_im_q      <= '0;
			m1_q        <= '0;
			m2_q        <= '0;
			m3_q        <= '0;
			m4_q        <= '0;
			pr_q        <= '0;
			pi_q        <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_acc) begin
						row_q  <= row_start;
						col_q  <= col_start;
						dend_q <= depth_end;
						r_q    <= '0;
						if (mode == sts_pkg::MODE_LOAD || bad) begin
							status_q    <= (mode == sts_pkg::MODE_LOAD) ? sts_pkg::ST_OK
							                                          : sts_pkg::ST_RANGE;
							val_re_q    <= '0;
							val_im_q    <= '0;
						end else begin
							state_q <= A_CHK;
						end
					end
				end
				A_CHK: begin
					if (XW'(r_q) == XW'(w_q)) begin
						state_q <= SC;
					end else begin
						a_q     <= a_idx;
						c_q     <= '0;
						state_q <= A_LATCH;
					end
				end
				A_LATCH: begin
					a_re_q  <= b_re;
					a_im_q  <= b_im;
					state_q <= B_CHK;
				end
				B_CHK: begin
					if (XW'(c_q) == XW'(w_q) || b_idx > a_q) begin
						r_q     <= r_q + 1'b1;
						state_q <= A_CHK;
					end else begin
						b_q     <= b_idx;
						state_q <= B_LATCH;
					end
				end
				B_LATCH: begin
					m1_q    <= a_re_q * b_re;
					m2_q    <= a_im_q * b_im;
					m3_q    <= a_re_q * b_im;
					m4_q    <= a_im_q * b_re;
					state_q <= B_SUM;
				end
				B_SUM: begin
					pr_q    <= sts_pkg::PROD_W'(m1_q) - sts_pkg::PROD_W'(m2_q);
					pi_q    <= sts_pkg::PROD_W'(m3_q) + sts_pkg::PROD_W'(m4_q);
					e_q     <= XW'(dend_q) + XW'(1) - XW'(w_q);
					state_q <= E_RUN;
				end
				E_RUN: begin
					if (e_ok) begin
						e_q <= e_q + 1'b1;
					end else begin
						state_q <= E_DRAIN;
					end
				end
				E_DRAIN: begin
					if (!term_busy) begin
						c_q     <= c_q + 1'b1;
						state_q <= B_CHK;
					end
				end
				SC: begin
					state_q <= SC_WAIT;
				end
				SC_WAIT: begin
					if (sc_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						status_q    <= sts_pkg::ST_OK;
						val_re_q    <= sc_re;
						val_im_q    <= sc_im;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_re  = signed'(val_re_q);
	assign value_im  = signed'(val_im_q);

	// terms are only issued while walking the inner loop and below the series length
	assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (state_q == E_RUN) && (s_idx < (XW+2)'(n_q)))
		else $error("term issued out of loop or beyond series length");

	// scaling starts only after the term pipeline has drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SC) |-> !term_busy)
		else $error("scaling started with terms in flight");

	// a new pair (a,b) is set up only with an empty term pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SUM) |-> !term_busy)
		else $error("product changed while terms in flight");

endmodule

// ===== bench/testbench.sv =====
module testbench;

	typedef struct packed {
		logic               status;
		logic signed [39:0] value_re;
		logic signed [39:0] value_im;
	} point_t;

	// bins 0..FILL_BINS-1 are loaded before any query
	localparam int FILL_BINS = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = sts_pkg::MODE_LOAD;
	logic [9:0] bin_index = '0;
	logic signed [15:0] bin_re = '0;
	logic signed [15:0] bin_im = '0;
	logic [9:0] row_start = '0;
	logic [9:0] col_start = '0;
	logic [9:0] depth_end = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic signed [39:0] value_re;
	logic signed [39:0] value_im;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sts_pkg::CFG_IDX_W-1:0] cfg_index = sts_pkg::CFG_SERIES_LENGTH;
	logic [15:0] cfg_data = '0;

	// shadow of the bin store and registers
	logic [31:0] bin_mem [sts_pkg::DEF_MAX_LEN];
	int unsigned cur_len = 32'(sts_pkg::RST_SERIES_LENGTH);
	int unsigned cur_win = 32'(sts_pkg::RST_WINDOW_SIZE);
	logic [15:0] cur_mant = sts_pkg::RST_SCALE_MANT;
	logic [5:0] cur_shift = sts_pkg::RST_SCALE_SHIFT;

	point_t expected_points[$];
	int errors = 0;
	bit steady = 1'b0;
	int sink_hold = 0;

	smoothed_trispectrum_point dut (.*);

	always #5 clk = ~clk;

	function automatic logic signed [127:0] part_re(int unsigned idx);
		logic signed [15:0] v;
		v = bin_mem[idx][31:16];
		return 128'(v);
	endfunction

	function automatic logic signed [127:0] part_im(int unsigned idx);
		logic signed [15:0] v;
		v = bin_mem[idx][15:0];
		return 128'(v);
	endfunction

	function automatic logic signed [39:0] scale_sat(logic signed [127:0] acc);
		logic signed [127:0] m;
		logic signed [127:0] x;
		m = 128'(cur_mant);
		x = (acc * m) >>> (int'(cur_shift) + sts_pkg::OUT_SHIFT_EXTRA);
		if (x > 128'sd549755813887)
			return 40'sh7F_FFFF_FFFF;
		if (x < -128'sd549755813888)
			return 40'sh80_0000_0000;
		return x[39:0];
	endfunction

	// box-smoothed trispectrum point over the window cube
	function automatic point_t smoothed_point(int unsigned r, int unsigned c, int unsigned d);
		point_t res;
		int unsigned n, w, ia, ib, a, b, e, s;
		logic signed [127:0] ar, ai, br, bi, pr, pi, qr, qi, er, ei, xr, xi;
		logic signed [127:0] acc_re, acc_im;
		n = cur_len;
		w = cur_win;
		res = '0;
		acc_re = '0;
		acc_im = '0;
		if (n == 0 || n > sts_pkg::DEF_MAX_LEN || w == 0 || w > sts_pkg::DEF_MAX_WIN ||
			w > n || r > n - w || c > n - w || d + 1 < w || d >= n) begin
			res.status = sts_pkg::ST_RANGE;
			return res;
		end
		for (ia = 0; ia < w; ia++) begin
			a = r + ia;
			ar = part_re(a);
			ai = part_im(a);
			for (ib = 0; ib < w; ib++) begin
				b = c + ib;
				if (b > a)
					break;
				br = part_re(b);
				bi = part_im(b);
				pr = ar * br - ai * bi;
				pi = ar * bi + ai * br;
				for (e = d + 1 - w; e <= d; e++) begin
					s = a + b + e;
					if (e > b || 2 * s >= n)
						break;
					er = part_re(e);
					ei = part_im(e);
					xr = part_re(s);
					xi = part_im(s);
					qr = er * xr + ei * xi;
					qi = ei * xr - er * xi;
					acc_re += pr * qr - pi * qi;
					acc_im += pr * qi + pi * qr;
				end
			end
		end
		res.status = sts_pkg::ST_OK;
		res.value_re = scale_sat(acc_re);
		res.value_im = scale_sat(acc_im);
		return res;
	endfunction

	// receiver side: random stall bursts, always ready in the steady phase
	always @(negedge clk) begin
		if (steady) begin
			out_ready = 1'b1;
		end else if (sink_hold > 0) begin
			out_ready = 1'b0;
			sink_hold--;
		end else if ($urandom_range(0, 6) == 0) begin
			out_ready = 1'b0;
			sink_hold = $urandom_range(0, 16);
		end else begin
			out_ready = 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		point_t exp_pt;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected result beat: status %0d re %0d im %0d",
					status, value_re, value_im);
				errors++;
			end else begin
				exp_pt = expected_points.pop_front();
				if (status !== exp_pt.status) begin
					$error("status: expected %0d, got %0d", exp_pt.status, status);
					errors++;
				end
				if (value_re !== exp_pt.value_re) begin
					$error("value_re: expected %0d, got %0d", exp_pt.value_re, value_re);
					errors++;
				end
				if (value_im !== exp_pt.value_im) begin
					$error("value_im: expected %0d, got %0d", exp_pt.value_im, value_im);
					errors++;
				end
			end
		end
	end

	// one input beat; called at a falling edge
	task automatic send_beat(logic m, logic [9:0] idx, logic [15:0] re, logic [15:0] im,
		logic [9:0] r, logic [9:0] c, logic [9:0] d);
		point_t res;
		if (!steady && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 17)) @(negedge clk);
		mode = m;
		bin_index = idx;
		bin_re = re;
		bin_im = im;
		row_start = r;
		col_start = c;
		depth_end = d;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (m == sts_pkg::MODE_LOAD) begin
			bin_mem[idx] = {re, im};
			res = '0;
		end else begin
			res = smoothed_point(32'(r), 32'(c), 32'(d));
		end
		expected_points = {expected_points, res};
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_load(int unsigned idx, int unsigned re, int unsigned im);
		send_beat(sts_pkg::MODE_LOAD, 10'(idx), 16'(re), 16'(im),
			10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	task automatic send_query(int unsigned r, int unsigned c, int unsigned d);
		send_beat(sts_pkg::MODE_QUERY, 10'($urandom), 16'($urandom), 16'($urandom),
			10'(r), 10'(c), 10'(d));
	endtask

	task automatic write_reg(logic [sts_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
		wait (expected_points.size() == 0);
		repeat (4) @(negedge clk);
		cfg_index = idx;
		cfg_data = 16'(data);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sts_pkg::CFG_SERIES_LENGTH: cur_len = data & 32'h7FF;
			sts_pkg::CFG_WINDOW_SIZE:   cur_win = data & 32'hFF;
			sts_pkg::CFG_SCALE_MANT:    cur_mant = 16'(data);
			sts_pkg::CFG_SCALE_SHIFT:   cur_shift = 6'(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_window(int unsigned n, int unsigned w, int unsigned m, int unsigned s);
		write_reg(sts_pkg::CFG_SERIES_LENGTH, n);
		write_reg(sts_pkg::CFG_WINDOW_SIZE, w);
		write_reg(sts_pkg::CFG_SCALE_MANT, m);
		write_reg(sts_pkg::CFG_SCALE_SHIFT, s);
	endtask

	// fill the low bins every query may touch and the top bin, full-scale values first
	task automatic test_fill_bins();
		send_load(0, 'h7FFF, 'h7FFF);
		send_load(1, 'h8000, 'h8000);
		send_load(2, 'h7FFF, 'h8000);
		for (int i = 3; i < FILL_BINS; i++)
			send_load(i, $urandom, $urandom);
		send_load(sts_pkg::DEF_MAX_LEN - 1, $urandom, $urandom);
	endtask

	// edges of the window, bad settings and register extremes
	task automatic test_directed();
		send_query(1023, 0, 0);
		set_window(16, 4, 65535, 0);
		send_query(0, 0, 3);
		send_query(12, 12, 15);
		send_query(13, 0, 3);
		send_query(0, 13, 3);
		send_query(0, 0, 2);
		send_query(0, 0, 16);
		set_window(1, 1, 0, 63);
		send_query(0, 0, 0);
		write_reg(sts_pkg::CFG_SCALE_MANT, 65535);
		write_reg(sts_pkg::CFG_SCALE_SHIFT, 0);
		send_query(0, 0, 0);
		set_window(8, 9, 1000, 10);
		send_query(0, 0, 7);
		write_reg(sts_pkg::CFG_WINDOW_SIZE, 0);
		send_query(0, 0, 0);
		set_window(0, 1, 1000, 10);
		send_query(0, 0, 0);
		write_reg(sts_pkg::CFG_SERIES_LENGTH, 2047);
		send_query(0, 0, 0);
		set_window(8, 2, 65535, 0);
		send_query(0, 0, 1);
		set_window(FILL_BINS, FILL_BINS, 40000, 20);
		send_query(0, 0, FILL_BINS - 1);
		set_window(1024, 1, 39140, 30);
		send_query(12, 8, 4);
		send_query(10, 10, 10);
	endtask

	// random loads and mostly in-range queries under one random setting
	task automatic random_phase(int items);
		int unsigned n, w, s, r, c, d;
		n = $urandom_range(1, FILL_BINS);
		w = $urandom_range(1, n < 10 ? n : 10);
		s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(8, 40);
		set_window(n, w, $urandom_range(0, 65535), s);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 9) < 4) begin
				if ($urandom_range(0, 1) == 0)
					send_load($urandom_range(0, FILL_BINS - 1), $urandom, $urandom);
				else
					send_load($urandom_range(0, sts_pkg::DEF_MAX_LEN - 1), $urandom, $urandom);
			end else if ($urandom_range(0, 6) == 0) begin
				send_query($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023));
			end else begin
				r = $urandom_range(0, n - w);
				c = $urandom_range(0, n - w);
				d = $urandom_range(w - 1, n - 1);
				send_query(r, c, d);
			end
		end
	endtask

	task automatic test_random();
		repeat (3) random_phase(12);
	endtask

	task automatic test_steady();
		steady = 1'b1;
		random_phase(14);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill_bins();
		test_directed();
		test_random();
		test_steady();
		wait (expected_points.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#40000000;
		$display("testbench: errors");
		$finish;
	end

endmodule

// ===== files.f =====
design/sts_pkg.sv
design/sts_store.sv
design/sts_term.sv
design/sts_scale.sv
design/smoothed_trispectrum_point.sv
bench/testbench.sv
